// ----- design/xfd_pkg.sv -----
// shared types and zero-count functions for the xor float delta encoder
`default_nettype none

package xfd_pkg;

  localparam int unsigned SampleWidth  = 64;
  localparam int unsigned CountWidth   = 6;
  localparam int unsigned LeadWidth    = 5;
  localparam int unsigned LengthWidth  = 7;
  localparam int unsigned LeadClip     = 31;

  typedef enum logic [1:0] {
    TOK_RAW   = 2'd0,
    TOK_SAME  = 2'd1,
    TOK_REUSE = 2'd2,
    TOK_NEW   = 2'd3
  } token_kind_e;

  // leading zero count of a nonzero word, six halving steps
  function automatic logic [CountWidth-1:0] lead_zeros(input logic [SampleWidth-1:0] v);
    logic [SampleWidth-1:0] w;
    logic [CountWidth-1:0]  n;
    w = v;
    n = '0;
    if (w[63:32] == '0) begin
      n[5] = 1'b1;
      w = w << 32;
    end
    if (w[63:48] == '0) begin
      n[4] = 1'b1;
      w = w << 16;
    end
    if (w[63:56] == '0) begin
      n[3] = 1'b1;
      w = w << 8;
    end
    if (w[63:60] == '0) begin
      n[2] = 1'b1;
      w = w << 4;
    end
    if (w[63:62] == '0) begin
      n[1] = 1'b1;
      w = w << 2;
    end
    if (w[63] == 1'b0) begin
      n[0] = 1'b1;
    end
    return n;
  endfunction

  // trailing zero count of a nonzero word
  function automatic logic [CountWidth-1:0] trail_zeros(input logic [SampleWidth-1:0] v);
    logic [SampleWidth-1:0] r;
    for (int i = 0; i < SampleWidth; i++) begin
      r[i] = v[SampleWidth-1-i];
    end
    return lead_zeros(r);
  endfunction

endpackage

`default_nettype wire

// ----- design/xor_float_delta_encoder.sv -----
// top level of the xor float delta encoder: input register, token logic, result register
//
// Takes one 64-bit double bit pattern per request and returns one token per request,
// in order. A request is taken into an input register, coded combinationally (xor
// with the previous sample, leading and trailing zero count, window compare, shift)
// and written to a result register; the history and window state update together
// with the result register, so a new request is taken every cycle while the output is
// not stalled, and a token is on the output once it is in the result register. The
// result register holds a token while the output is stalled, and the input register
// keeps taking one more request meanwhile. No clearing pass after reset.
`default_nettype none

module xor_float_delta_encoder (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic [xfd_pkg::SampleWidth-1:0]   sample_bits_i,
  input  wire logic                              series_start_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic [1:0]                             token_kind_o,
  output logic [xfd_pkg::LeadWidth-1:0]          lead_zero_field_o,
  output logic [xfd_pkg::CountWidth-1:0]         length_field_o,
  output logic [xfd_pkg::SampleWidth-1:0]        payload_o,
  output logic [xfd_pkg::LengthWidth-1:0]        payload_length_o
);

  // input register
  logic                            s1_valid_q;
  logic [xfd_pkg::SampleWidth-1:0] s1_bits_q;
  logic                            s1_start_q;

  // history and window state
  logic [xfd_pkg::SampleWidth-1:0] prev_q, prev_d;
  logic                            have_prev_q, have_prev_d;
  logic                            win_active_q, win_active_d;
  logic [xfd_pkg::LeadWidth-1:0]   win_lead_q, win_lead_d;
  logic [xfd_pkg::CountWidth-1:0]  win_trail_q, win_trail_d;
  logic [xfd_pkg::LengthWidth-1:0] win_len_q, win_len_d;

  // result register
  logic                            out_valid_q;
  xfd_pkg::token_kind_e            kind_q, kind_d;
  logic [xfd_pkg::LeadWidth-1:0]   lead_f_q, lead_f_d;
  logic [xfd_pkg::CountWidth-1:0]  len_f_q, len_f_d;
  logic [xfd_pkg::SampleWidth-1:0] payload_q, payload_d;
  logic [xfd_pkg::LengthWidth-1:0] plen_q, plen_d;

  logic                            advance;
  logic                            s1_fire;
  logic [xfd_pkg::SampleWidth-1:0] xor_w;
  logic [xfd_pkg::CountWidth-1:0]  lz, tz;
  logic [xfd_pkg::LeadWidth-1:0]   lz_clip;
  logic                            reuse;

  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || advance;
  assign s1_fire    = s1_valid_q && advance;

  assign xor_w   = s1_bits_q ^ prev_q;
  assign lz      = xfd_pkg::lead_zeros(xor_w);
  assign tz      = xfd_pkg::trail_zeros(xor_w);
  assign lz_clip = (lz > xfd_pkg::CountWidth'(xfd_pkg::LeadClip))
                   ? xfd_pkg::LeadWidth'(xfd_pkg::LeadClip) : lz[xfd_pkg::LeadWidth-1:0];
  assign reuse   = win_active_q && ({1'b0, win_lead_q} <= lz) && (win_trail_q <= tz);

  always_comb begin
    prev_d       = s1_bits_q;
    have_prev_d  = have_prev_q;
    win_active_d = win_active_q;
    win_lead_d   = win_lead_q;
    win_trail_d  = win_trail_q;
    win_len_d    = win_len_q;
    kind_d       = xfd_pkg::TOK_RAW;
    lead_f_d     = '0;
    len_f_d      = '0;
    payload_d    = '0;
    plen_d       = '0;
    if (s1_start_q || !have_prev_q) begin
      kind_d       = xfd_pkg::TOK_RAW;
      payload_d    = s1_bits_q;
      plen_d       = xfd_pkg::LengthWidth'(xfd_pkg::SampleWidth);
      win_active_d = 1'b0;
      have_prev_d  = 1'b1;
    end else if (xor_w == '0) begin
      kind_d = xfd_pkg::TOK_SAME;
    end else if (reuse) begin
      kind_d    = xfd_pkg::TOK_REUSE;
      payload_d = xor_w >> win_trail_q;
      plen_d    = win_len_q;
    end else begin
      kind_d       = xfd_pkg::TOK_NEW;
      win_active_d = 1'b1;
      win_lead_d   = lz_clip;
      win_trail_d  = tz;
      win_len_d    = xfd_pkg::LengthWidth'(xfd_pkg::SampleWidth)
                     - {2'b00, lz_clip} - {1'b0, tz};
      lead_f_d     = lz_clip;
      // a full 64-bit length truncates to 0
      len_f_d      = win_len_d[xfd_pkg::CountWidth-1:0];
      payload_d    = xor_w >> tz;
      plen_d       = win_len_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      prev_q       <= '0;
      have_prev_q  <= 1'b0;
      win_active_q <= 1'b0;
      win_lead_q   <= '0;
      win_trail_q  <= '0;
      win_len_q    <= '0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= s1_valid_q;
      end
      if (s1_fire) begin
        prev_q       <= prev_d;
        have_prev_q  <= have_prev_d;
        win_active_q <= win_active_d;
        win_lead_q   <= win_lead_d;
        win_trail_q  <= win_trail_d;
        win_len_q    <= win_len_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_bits_q  <= sample_bits_i;
      s1_start_q <= series_start_i;
    end
    if (s1_fire) begin
      kind_q    <= kind_d;
      lead_f_q  <= lead_f_d;
      len_f_q   <= len_f_d;
      payload_q <= payload_d;
      plen_q    <= plen_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign token_kind_o      = kind_q;
  assign lead_zero_field_o = lead_f_q;
  assign length_field_o    = len_f_q;
  assign payload_o         = payload_q;
  assign payload_length_o  = plen_q;

  // payload never carries bits above its stated length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (token_kind_o != xfd_pkg::TOK_RAW) |-> (payload_o >> payload_length_o) == '0)
    else $error("payload wider than payload_length");

  // a new window is aligned on its lowest set bit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (token_kind_o == xfd_pkg::TOK_NEW) |-> payload_o[0])
    else $error("new window payload not aligned");

  // identical tokens carry nothing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (token_kind_o == xfd_pkg::TOK_SAME) |->
      (payload_o == '0) && (payload_length_o == '0))
    else $error("identical token carries payload");

  // a stalled result with a full input register blocks new requests
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i && s1_valid_q |-> !in_ready_o)
    else $error("request taken while both registers full");

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
// testbench for the xor float delta encoder: directed table, random series, token predictor
`timescale 1ns / 100ps

module tb;

  localparam int unsigned NumDirected = 21;
  localparam int unsigned NumRandom   = 1930;
  localparam int unsigned HoldCycles  = 64;
  localparam int unsigned QuietLimit  = 1000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned IdlePercent = 13;

  typedef struct packed {
    xfd_pkg::token_kind_e kind;
    logic [4:0]           lead;
    logic [5:0]           len;
    logic [63:0]          payload;
    logic [6:0]           plen;
  } token_t;

  typedef struct packed {
    logic [63:0] bits;
    logic        start;
    logic        typed;
    token_t      tok;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [63:0] sample_bits_i;
  logic        series_start_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [1:0]  token_kind_o;
  logic [4:0]  lead_zero_field_o;
  logic [5:0]  length_field_o;
  logic [63:0] payload_o;
  logic [6:0]  payload_length_o;

  // predictor state
  logic [63:0] prev_bits;
  logic        prev_valid;
  logic        win_open;
  logic [4:0]  win_lead;
  logic [5:0]  win_trail;
  logic [6:0]  win_len;

  token_t      expected_tokens[$];
  row_t        directed_rows [NumDirected];
  int unsigned mismatch_count;
  int unsigned quiet_cycles;
  logic        calm;
  logic        hold_off;

  xor_float_delta_encoder i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .sample_bits_i     (sample_bits_i),
    .series_start_i    (series_start_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .token_kind_o      (token_kind_o),
    .lead_zero_field_o (lead_zero_field_o),
    .length_field_o    (length_field_o),
    .payload_o         (payload_o),
    .payload_length_o  (payload_length_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic token_t code_sample(input logic [63:0] bits, input logic start);
    token_t      tok;
    logic [63:0] diff;
    int unsigned lz;
    int unsigned tz;
    tok.kind    = xfd_pkg::TOK_RAW;
    tok.lead    = '0;
    tok.len     = '0;
    tok.payload = '0;
    tok.plen    = '0;
    if (start || !prev_valid) begin
      tok.payload = bits;
      tok.plen    = 7'd64;
      win_open    = 1'b0;
      prev_valid  = 1'b1;
    end else begin
      diff = bits ^ prev_bits;
      if (diff == '0) begin
        tok.kind = xfd_pkg::TOK_SAME;
      end else begin
        lz = 0;
        while (!diff[63 - lz]) lz++;
        tz = 0;
        while (!diff[tz]) tz++;
        if (win_open && win_lead <= lz && win_trail <= tz) begin
          tok.kind = xfd_pkg::TOK_REUSE;
        end else begin
          if (lz > xfd_pkg::LeadClip) lz = xfd_pkg::LeadClip;
          win_open  = 1'b1;
          win_lead  = lz[4:0];
          win_trail = tz[5:0];
          win_len   = 7'(64 - lz - tz);
          tok.kind  = xfd_pkg::TOK_NEW;
          tok.lead  = win_lead;
          tok.len   = win_len[5:0];
        end
        tok.payload = diff >> win_trail;
        tok.plen    = win_len;
      end
    end
    prev_bits = bits;
    return tok;
  endfunction

  task automatic offer_sample(input logic [63:0] bits, input logic start,
                              input logic typed, input token_t typed_tok);
    token_t pred;
    @(negedge clk_i);
    while (!calm && $urandom_range(0, 99) < IdlePercent) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    sample_bits_i  <= bits;
    series_start_i <= start;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pred = code_sample(bits, start);
    expected_tokens.insert(expected_tokens.size(), typed ? typed_tok : pred);
  endtask

  task automatic wait_all_tokens();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk_i);
  endtask

  task automatic check_token();
    token_t want;
    if (expected_tokens.size() == 0) begin
      $error("token with no request outstanding: kind %0d payload %h", token_kind_o, payload_o);
      mismatch_count++;
    end else begin
      want = expected_tokens.pop_front();
      if (token_kind_o !== want.kind) begin
        $error("token_kind: expected %0d, got %0d", want.kind, token_kind_o);
        mismatch_count++;
      end
      if (lead_zero_field_o !== want.lead) begin
        $error("lead_zero_field: expected %0d, got %0d", want.lead, lead_zero_field_o);
        mismatch_count++;
      end
      if (length_field_o !== want.len) begin
        $error("length_field: expected %0d, got %0d", want.len, length_field_o);
        mismatch_count++;
      end
      if (payload_o !== want.payload) begin
        $error("payload: expected %h, got %h", want.payload, payload_o);
        mismatch_count++;
      end
      if (payload_length_o !== want.plen) begin
        $error("payload_length: expected %0d, got %0d", want.plen, payload_length_o);
        mismatch_count++;
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) check_token();
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // receiver, with one long hold-off on request from the sender
  initial begin
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        hold_off = 1'b0;
      end else begin
        out_ready_i <= calm || ($urandom_range(0, 99) >= IdlePercent);
      end
    end
  end

  initial begin
    logic [63:0] last_bits;
    logic [63:0] next_bits;
    logic [63:0] flip;
    logic        next_start;
    int unsigned pick;
    token_t      none;

    none           = '{xfd_pkg::TOK_RAW, 5'd0, 6'd0, 64'h0, 7'd0};
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    sample_bits_i  = '0;
    series_start_i = 1'b0;
    prev_bits      = '0;
    prev_valid     = 1'b0;
    win_open       = 1'b0;
    win_lead       = '0;
    win_trail      = '0;
    win_len        = '0;
    mismatch_count = 0;
    quiet_cycles   = 0;
    calm           = 1'b0;
    hold_off       = 1'b0;

    directed_rows = '{
      '{64'h0000_0000_0000_0000, 1'b0, 1'b1,
        '{xfd_pkg::TOK_RAW, 5'd0, 6'd0, 64'h0000_0000_0000_0000, 7'd64}},
      '{64'h0000_0000_0000_0000, 1'b0, 1'b1,
        '{xfd_pkg::TOK_SAME, 5'd0, 6'd0, 64'h0, 7'd0}},
      '{64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b1,
        '{xfd_pkg::TOK_NEW, 5'd0, 6'd0, 64'hFFFF_FFFF_FFFF_FFFF, 7'd64}},
      '{64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b1,
        '{xfd_pkg::TOK_SAME, 5'd0, 6'd0, 64'h0, 7'd0}},
      '{64'hFFFF_FFFF_FFFF_FFFE, 1'b0, 1'b1,
        '{xfd_pkg::TOK_REUSE, 5'd0, 6'd0, 64'h0000_0000_0000_0001, 7'd64}},
      '{64'h7FFF_FFFF_FFFF_FFFE, 1'b0, 1'b1,
        '{xfd_pkg::TOK_REUSE, 5'd0, 6'd0, 64'h8000_0000_0000_0000, 7'd64}},
      '{64'h3FF0_0000_0000_0000, 1'b1, 1'b1,
        '{xfd_pkg::TOK_RAW, 5'd0, 6'd0, 64'h3FF0_0000_0000_0000, 7'd64}},
      '{64'h4000_0000_0000_0000, 1'b0, 1'b0, none},
      '{64'h4000_0000_0000_0001, 1'b0, 1'b0, none},
      '{64'h4000_0000_0000_0003, 1'b0, 1'b0, none},
      '{64'h4000_0000_0000_0003, 1'b0, 1'b0, none},
      '{64'hC000_0000_0000_0003, 1'b0, 1'b0, none},
      '{64'h4000_0000_0000_0003, 1'b0, 1'b0, none},
      '{64'h4000_0000_0000_0003, 1'b1, 1'b1,
        '{xfd_pkg::TOK_RAW, 5'd0, 6'd0, 64'h4000_0000_0000_0003, 7'd64}},
      '{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1,
        '{xfd_pkg::TOK_RAW, 5'd0, 6'd0, 64'hFFFF_FFFF_FFFF_FFFF, 7'd64}},
      '{64'h0000_0000_0000_0000, 1'b0, 1'b1,
        '{xfd_pkg::TOK_NEW, 5'd0, 6'd0, 64'hFFFF_FFFF_FFFF_FFFF, 7'd64}},
      '{64'h0000_0001_0000_0000, 1'b0, 1'b0, none},
      '{64'h8000_0000_0000_0001, 1'b1, 1'b0, none},
      '{64'h8000_0000_0000_0000, 1'b0, 1'b0, none},
      '{64'h0000_0000_8000_0000, 1'b0, 1'b0, none},
      '{64'h0000_0000_0000_0000, 1'b0, 1'b0, none}
    };

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int i = 0; i < NumDirected; i++) begin
      offer_sample(directed_rows[i].bits, directed_rows[i].start,
                   directed_rows[i].typed, directed_rows[i].tok);
    end
    wait_all_tokens();

    // random series: mostly small changes inside a window, some repeats and restarts
    last_bits = directed_rows[NumDirected-1].bits;
    for (int i = 0; i < NumRandom; i++) begin
      if (i == 400) hold_off = 1'b1;
      if (i == 900) wait_all_tokens();
      calm       = (i >= 1200 && i < 1500);
      pick       = $urandom_range(0, 99);
      next_start = 1'b0;
      if (pick < 5) begin
        next_start = 1'b1;
        next_bits  = {$urandom, $urandom};
      end else if (pick < 20) begin
        next_bits = last_bits;
      end else if (pick < 85) begin
        flip      = ({$urandom, $urandom} >> $urandom_range(0, 63)) << $urandom_range(0, 40);
        next_bits = last_bits ^ flip;
      end else begin
        next_bits = {$urandom, $urandom};
      end
      offer_sample(next_bits, next_start, 1'b0, none);
      last_bits = next_bits;
    end
    calm = 1'b0;
    wait_all_tokens();
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
